@@ src/ctnhr_pkg.sv @@
// Shared types, constants and helpers for the cell topology next-hop router.
`timescale 1ns / 1ps

package ctnhr_pkg;

  localparam int ID_W   = 16;
  localparam int RS_W   = 6;
  localparam int GEO_W  = 4;
  localparam int BASE_W = 9;
  localparam int OFF_W  = RS_W + BASE_W;
  localparam int Q_W    = 15;
  localparam int RCP_W  = 15;
  localparam int PAIR_W = GEO_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RACK_SERVERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT  = 2'd2;

  localparam logic [RS_W-1:0]  RACK_SERVERS_RST = 6'd4;
  localparam logic [GEO_W-1:0] HALF_WIDTH_RST   = 4'd2;
  localparam logic [GEO_W-1:0] HALF_HEIGHT_RST  = 4'd2;

  // floor(65536 / (2x+1)), indexed by the effective half width
  localparam logic [RCP_W-1:0] RECIP_TBL [16] = '{
    15'd21845, 15'd21845, 15'd13107, 15'd9362, 15'd7281, 15'd5957, 15'd5041, 15'd4369,
    15'd3855,  15'd3449,  15'd3120,  15'd2849, 15'd2621, 15'd2427, 15'd2259, 15'd2114
  };

  typedef struct packed {
    logic [ID_W-1:0]  cur;
    logic             tie;
    logic [OFF_W-1:0] off;
    logic             rej;
    logic             arr;
  } meta_t;

  typedef struct packed {
    logic [ID_W-1:0]  row;
    logic [GEO_W-1:0] col;
  } split_t;

  function automatic logic [GEO_W-1:0] geom(input logic [GEO_W-1:0] v);
    geom = (v == '0) ? GEO_W'(1) : v;
  endfunction

  function automatic logic [BASE_W-1:0] grid_base(input logic [GEO_W-1:0] hw,
                                                  input logic [GEO_W-1:0] hh);
    logic [GEO_W-1:0]  gx;
    logic [GEO_W-1:0]  gy;
    logic [BASE_W-1:0] xy;
    gx = geom(hw);
    gy = geom(hh);
    xy = BASE_W'(gx * gy);
    grid_base = BASE_W'({xy, 1'b0}) + BASE_W'(gy) - BASE_W'(gx) - BASE_W'(1);
  endfunction

  function automatic split_t split_fix(input logic [ID_W-1:0]  s,
                                       input logic [ID_W-1:0]  qp,
                                       input logic [Q_W-1:0]   q,
                                       input logic [GEO_W-1:0] gx);
    logic [ID_W-1:0] rem;
    logic [ID_W-1:0] qc;
    logic [ID_W-1:0] pair;
    split_t r;
    pair = ID_W'({gx, 1'b1});
    rem  = s - qp;
    qc   = ID_W'(q);
    if (rem >= pair) begin
      rem = rem - pair;
      qc  = qc + ID_W'(1);
    end
    r.row = {qc[ID_W-2:0], 1'b0};
    r.col = rem[GEO_W-1:0];
    if (rem >= ID_W'(gx)) begin
      r.row[0] = 1'b1;
      r.col    = GEO_W'(rem - ID_W'(gx));
    end
    split_fix = r;
  endfunction

endpackage

@@ src/cell_topology_next_hop_router_unit.sv @@
// Top level of the cell topology next-hop router: seven-stage pipelined route lookup.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one lookup per item (current node, target node, tie bit), valid/ready.
//   out_* : one result per item (next node, arrived, rejected), valid/ready.
//   cfg_* : register writes (index 0 rack servers, 1 half width, 2 half height);
//           cfg_ready is always high. Write only while no item is in flight.
// Pipeline: seven register stages (offset product, offset subtract, reciprocal
//   multiply, quotient back-multiply, remainder correction, port choice, id
//   rebuild). Throughput: one item per cycle while out_ready stays high, set by
//   the per-stage pipeline; every stage holds one item.
// Stalls: each stage loads when it is empty or the stage after it moves, so
//   bubbles close up while out_ready is low; items are held, never dropped.
// Reset: rst_n low clears all valid bits and restores the registers to
//   rack servers 4, half width 2, half height 2.
// Ids below the switch offset give rejected with next node 0; equal ids not
//   below it give arrived with next node equal to the current node.
module cell_topology_next_hop_router_unit
  import ctnhr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ID_W-1:0]       in_current_node,
  input  logic [ID_W-1:0]       in_target_node,
  input  logic                  in_tie_bit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       out_next_node,
  output logic                  out_arrived,
  output logic                  out_rejected,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [RS_W-1:0]   rack_servers_r, rack_servers_nxt;
  logic [GEO_W-1:0]  half_width_r, half_width_nxt;
  logic [GEO_W-1:0]  half_height_r, half_height_nxt;
  logic [BASE_W-1:0] base_r;
  logic [GEO_W-1:0]  gx, gy;
  logic [PAIR_W-1:0] pair;
  logic [RCP_W-1:0]  recip;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  logic [ID_W-1:0] s1_dst_r;
  meta_t           s1_m_r, s2_m_r, s3_m_r, s4_m_r, s5_m_r, s6_m_r;
  meta_t           s2_m_nxt;
  logic [ID_W-1:0] s2_sc_r, s2_sd_r, s3_sc_r, s3_sd_r, s4_sc_r, s4_sd_r;
  logic [Q_W-1:0]  s3_qc_r, s3_qd_r, s4_qc_r, s4_qd_r;
  logic [ID_W-1:0] s4_qpc_r, s4_qpd_r;
  split_t          s5_w_r, s5_t_r, sp_w, sp_t;
  logic [ID_W-1:0] s6_wy_r, nwy;
  logic [GEO_W:0]  s6_wx_r, nwx;

  logic [ID_W-1:0] out_next_node_r;
  logic            out_arrived_r, out_rejected_r;

  logic [2*ID_W-1:0] prod_c, prod_d;
  logic [Q_W+PAIR_W-1:0] qp_c, qp_d;
  logic signed [17:0] dx, dy;
  logic [ID_W+GEO_W:0] id_sum;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    rack_servers_nxt = rack_servers_r;
    half_width_nxt   = half_width_r;
    half_height_nxt  = half_height_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RACK_SERVERS: rack_servers_nxt = cfg_data[RS_W-1:0];
        CFG_HALF_WIDTH:   half_width_nxt   = cfg_data[GEO_W-1:0];
        CFG_HALF_HEIGHT:  half_height_nxt  = cfg_data[GEO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rack_servers_r <= RACK_SERVERS_RST;
      half_width_r   <= HALF_WIDTH_RST;
      half_height_r  <= HALF_HEIGHT_RST;
      base_r         <= grid_base(HALF_WIDTH_RST, HALF_HEIGHT_RST);
    end else begin
      rack_servers_r <= rack_servers_nxt;
      half_width_r   <= half_width_nxt;
      half_height_r  <= half_height_nxt;
      base_r         <= grid_base(half_width_nxt, half_height_nxt);
    end
  end

  assign gx    = geom(half_width_r);
  assign gy    = geom(half_height_r);
  assign pair  = {gx, 1'b1};
  assign recip = RECIP_TBL[gx];

  // stage enables
  assign en7 = !s7_v_r || out_ready;
  assign en6 = !s6_v_r || en7;
  assign en5 = !s5_v_r || en6;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
      if (en5) s5_v_r <= s4_v_r;
      if (en6) s6_v_r <= s5_v_r;
      if (en7) s7_v_r <= s6_v_r;
    end
  end

  // datapath
  always_comb begin
    s2_m_nxt     = s1_m_r;
    s2_m_nxt.rej = (s1_m_r.cur < ID_W'(s1_m_r.off)) || (s1_dst_r < ID_W'(s1_m_r.off));
    s2_m_nxt.arr = s1_m_r.cur == s1_dst_r;
  end

  assign prod_c = s2_sc_r * {1'b0, recip};
  assign prod_d = s2_sd_r * {1'b0, recip};
  assign qp_c   = s3_qc_r * pair;
  assign qp_d   = s3_qd_r * pair;
  assign sp_w   = split_fix(s4_sc_r, s4_qpc_r, s4_qc_r, gx);
  assign sp_t   = split_fix(s4_sd_r, s4_qpd_r, s4_qd_r, gx);

  always_comb begin
    dx  = $signed({14'd0, s5_t_r.col}) - $signed({14'd0, s5_w_r.col});
    dy  = $signed({2'd0, s5_t_r.row}) - $signed({2'd0, s5_w_r.row});
    nwy = s5_w_r.row;
    nwx = {1'b0, s5_w_r.col};
    if (!s5_w_r.row[0]) begin
      if (dx > 0 && dy > 0 && dx >= dy) begin
        nwx = nwx + 5'd1;
        nwy = nwy + 16'd1;
      end else if (dy > 1) begin
        nwy = nwy + 16'd2;
      end else if (dx <= 0 && dy > 0) begin
        nwy = nwy + 16'd1;
      end else if (dy < -1) begin
        nwy = nwy - 16'd2;
      end else if (dx <= 0 && dy < 0) begin
        nwy = nwy - 16'd1;
      end else if (dx > 0 && dy < 0 && dx >= -dy) begin
        nwx = nwx + 5'd1;
        nwy = nwy - 16'd1;
      end else if (dy == 0 && dx != 0) begin
        if (dx > 0) nwx = nwx + 5'd1;
        if (s5_w_r.row == '0) nwy = nwy + 16'd1;
        else if (s5_w_r.row == ID_W'({gy, 1'b0})) nwy = nwy - 16'd1;
        else if (s5_m_r.tie) nwy = nwy + 16'd1;
        else nwy = nwy - 16'd1;
      end
    end else begin
      if (dx > 0 && dy < 0 && dx <= -dy) begin
        nwy = nwy - 16'd1;
      end else if (dx > 0 && (dy == 0 || (dy < 0 && dx > -dy) || (dy > 0 && dx > dy))) begin
        nwx = nwx + 5'd1;
      end else if (dx > 0 && dy > 0 && dx <= dy) begin
        nwy = nwy + 16'd1;
      end else if (dx < 0 && dy > 0 && -dx <= dy) begin
        nwx = nwx - 5'd1;
        nwy = nwy + 16'd1;
      end else if (dx < 0 && (dy == 0 || (dy > 0 && -dx > dy) || (dy < 0 && -dx > -dy))) begin
        nwx = nwx - 5'd1;
      end else if (dx < 0 && dy < 0 && -dx <= -dy) begin
        nwx = nwx - 5'd1;
        nwy = nwy - 16'd1;
      end else if (dx == 0 && dy != 0) begin
        if (dy > 0) nwy = nwy + 16'd1;
        else nwy = nwy - 16'd1;
        if (s5_w_r.col == '0 || dy == 1 || dy == -1) begin
        end else if ({1'b0, s5_w_r.col} == {gx, 1'b0}) begin
          nwx = nwx - 5'd1;
        end else if (!s5_m_r.tie) begin
          nwx = nwx - 5'd1;
        end
      end
    end
  end

  assign id_sum = (ID_W+GEO_W+1)'(s6_wy_r * gx) + (ID_W+GEO_W+1)'(s6_wy_r >> 1)
                + (ID_W+GEO_W+1)'(s6_wx_r) + (ID_W+GEO_W+1)'(s6_m_r.off);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_m_r.cur <= in_current_node;
      s1_m_r.tie <= in_tie_bit;
      s1_m_r.off <= OFF_W'(rack_servers_r * base_r);
      s1_m_r.rej <= 1'b0;
      s1_m_r.arr <= 1'b0;
      s1_dst_r   <= in_target_node;
    end
    if (en2) begin
      s2_m_r     <= s2_m_nxt;
      s2_sc_r    <= s1_m_r.cur - ID_W'(s1_m_r.off);
      s2_sd_r    <= s1_dst_r - ID_W'(s1_m_r.off);
    end
    if (en3) begin
      s3_m_r  <= s2_m_r;
      s3_sc_r <= s2_sc_r;
      s3_sd_r <= s2_sd_r;
      s3_qc_r <= prod_c[ID_W+Q_W-1:ID_W];
      s3_qd_r <= prod_d[ID_W+Q_W-1:ID_W];
    end
    if (en4) begin
      s4_m_r   <= s3_m_r;
      s4_sc_r  <= s3_sc_r;
      s4_sd_r  <= s3_sd_r;
      s4_qc_r  <= s3_qc_r;
      s4_qd_r  <= s3_qd_r;
      s4_qpc_r <= qp_c[ID_W-1:0];
      s4_qpd_r <= qp_d[ID_W-1:0];
    end
    if (en5) begin
      s5_m_r <= s4_m_r;
      s5_w_r <= sp_w;
      s5_t_r <= sp_t;
    end
    if (en6) begin
      s6_m_r  <= s5_m_r;
      s6_wy_r <= nwy;
      s6_wx_r <= nwx;
    end
    if (en7) begin
      out_arrived_r  <= s6_m_r.arr && !s6_m_r.rej;
      out_rejected_r <= s6_m_r.rej;
      if (s6_m_r.rej) out_next_node_r <= '0;
      else if (s6_m_r.arr) out_next_node_r <= s6_m_r.cur;
      else out_next_node_r <= id_sum[ID_W-1:0];
    end
  end

  assign out_valid     = s7_v_r;
  assign out_next_node = out_next_node_r;
  assign out_arrived   = out_arrived_r;
  assign out_rejected  = out_rejected_r;

endmodule

@@ sim/cell_topology_next_hop_router_unit_tb.sv @@
// Self-checking testbench for the staggered-row grid next-hop router: random and directed lookups.
`timescale 1ns / 1ps

module cell_topology_next_hop_router_unit_tb
  import ctnhr_pkg::*;
();

  localparam int STALL_LIMIT  = 5000;
  localparam int SETTINGS_N   = 8;
  localparam int LOOKUPS_PER  = 203;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [ID_W-1:0] next_node;
    logic            arrived;
    logic            rejected;
  } hop_t;

  class route_scoreboard;
    bit [5:0] rack_servers;
    bit [3:0] half_width;
    bit [3:0] half_height;
    hop_t     pending_hops[$];
    int       errors;
    int       checked;
    int       arrivals;
    int       rejections;

    function new();
      rack_servers = RACK_SERVERS_RST;
      half_width   = HALF_WIDTH_RST;
      half_height  = HALF_HEIGHT_RST;
      errors = 0;
      checked = 0;
      arrivals = 0;
      rejections = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RACK_SERVERS: rack_servers = val[5:0];
        CFG_HALF_WIDTH:   half_width   = val[3:0];
        CFG_HALF_HEIGHT:  half_height  = val[3:0];
        default: ;
      endcase
    endfunction

    function void split_switch(input longint s, input longint x,
                               output longint col, output longint row);
      longint pair;
      longint rem;
      pair = 2 * x + 1;
      rem  = s % pair;
      row  = 2 * (s / pair);
      if (rem >= x) begin
        row = row + 1;
        col = rem - x;
      end else begin
        col = rem;
      end
    endfunction

    function hop_t predict_hop(logic [ID_W-1:0] cur, logic [ID_W-1:0] dst, logic tie);
      longint x, y, off, c, d, wx, wy, tx, ty, dx, dy;
      hop_t   h;
      x   = (half_width == 0) ? 1 : longint'(half_width);
      y   = (half_height == 0) ? 1 : longint'(half_height);
      off = longint'(rack_servers) * (2 * x * y + y - x - 1);
      c   = longint'(cur);
      d   = longint'(dst);
      h   = '0;
      if (c < off || d < off) begin
        h.rejected = 1'b1;
        return h;
      end
      if (c == d) begin
        h.next_node = cur;
        h.arrived   = 1'b1;
        return h;
      end
      split_switch(c - off, x, wx, wy);
      split_switch(d - off, x, tx, ty);
      dx = tx - wx;
      dy = ty - wy;
      if (wy % 2 == 0) begin
        if (dx > 0 && dy > 0 && dx >= dy) begin
          wx += 1;
          wy += 1;
        end else if (dy > 1) begin
          wy += 2;
        end else if (dx <= 0 && dy > 0) begin
          wy += 1;
        end else if (dy < -1) begin
          wy -= 2;
        end else if (dx <= 0 && dy < 0) begin
          wy -= 1;
        end else if (dx > 0 && dy < 0 && dx >= -dy) begin
          wx += 1;
          wy -= 1;
        end else if (dy == 0 && dx != 0) begin
          if (dx > 0) wx += 1;
          if (wy == 0) wy += 1;
          else if (wy == 2 * y) wy -= 1;
          else if (tie) wy += 1;
          else wy -= 1;
        end
      end else begin
        if (dx > 0 && dy < 0 && dx <= -dy) begin
          wy -= 1;
        end else if ((dx > 0 && dy == 0) || (dx > 0 && dy < 0 && dx > -dy) ||
                     (dx > 0 && dy > 0 && dx > dy)) begin
          wx += 1;
        end else if (dx > 0 && dy > 0 && dx <= dy) begin
          wy += 1;
        end else if (dx < 0 && dy > 0 && -dx <= dy) begin
          wx -= 1;
          wy += 1;
        end else if ((dx < 0 && dy == 0) || (dx < 0 && dy > 0 && -dx > dy) ||
                     (dx < 0 && dy < 0 && -dx > -dy)) begin
          wx -= 1;
        end else if (dx < 0 && dy < 0 && -dx <= -dy) begin
          wx -= 1;
          wy -= 1;
        end else if (dx == 0 && dy != 0) begin
          if (dy > 0) wy += 1;
          else wy -= 1;
          if (wx == 0 || dy == 1 || dy == -1) begin
          end else if (wx == 2 * x) begin
            wx -= 1;
          end else if (!tie) begin
            wx -= 1;
          end
        end
      end
      h.next_node = ID_W'(wy * x + wy / 2 + wx + off);
      return h;
    endfunction

    function void note_lookup(logic [ID_W-1:0] cur, logic [ID_W-1:0] dst, logic tie);
      pending_hops.push_back(predict_hop(cur, dst, tie));
    endfunction

    function void check_result(logic [ID_W-1:0] nn, logic arr, logic rej);
      hop_t exp_hop;
      if (pending_hops.size() == 0) begin
        $display("%0t: unexpected result next_node=%h arrived=%b rejected=%b",
                 $time, nn, arr, rej);
        errors++;
        return;
      end
      exp_hop = pending_hops.pop_front();
      checked++;
      if (exp_hop.arrived) arrivals++;
      if (exp_hop.rejected) rejections++;
      if (nn !== exp_hop.next_node) begin
        $display("%0t: next_node expected %h actual %h", $time, exp_hop.next_node, nn);
        errors++;
      end
      if (arr !== exp_hop.arrived) begin
        $display("%0t: arrived expected %b actual %b", $time, exp_hop.arrived, arr);
        errors++;
      end
      if (rej !== exp_hop.rejected) begin
        $display("%0t: rejected expected %b actual %b", $time, exp_hop.rejected, rej);
        errors++;
      end
    endfunction

    function void flag_leftovers();
      if (pending_hops.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, pending_hops.size());
        errors += pending_hops.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ID_W-1:0]       in_current_node = '0;
  logic [ID_W-1:0]       in_target_node = '0;
  logic                  in_tie_bit = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       out_next_node;
  logic                  out_arrived;
  logic                  out_rejected;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RACK_SERVERS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  route_scoreboard sb;
  int in_idle_pct = 8;
  int out_idle_pct = 60;
  int stall_cycles = 0;
  int lookups = 0;
  int gx, gy, goff, gcount;

  int set_rs[SETTINGS_N] = '{1, 48, 63, 0, 13, 48, 2, 4};
  int set_hw[SETTINGS_N] = '{1, 15, 0, 7, 3, 1, 15, 2};
  int set_hh[SETTINGS_N] = '{1, 15, 0, 3, 5, 15, 1, 2};

  cell_topology_next_hop_router_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_current_node (in_current_node),
    .in_target_node  (in_target_node),
    .in_tie_bit      (in_tie_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_node   (out_next_node),
    .out_arrived     (out_arrived),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_next_node, out_arrived, out_rejected);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("** cell_topology_next_hop_router_unit: FAILED **");
      $finish;
    end
  end

  function automatic void set_geometry(int rs, int hw, int hh);
    gx = (hw == 0) ? 1 : hw;
    gy = (hh == 0) ? 1 : hh;
    goff = rs * (2 * gx * gy + gy - gx - 1);
    gcount = 2 * gx * gy + gx + gy;
  endfunction

  function automatic logic [ID_W-1:0] switch_id(int row, int col);
    return ID_W'(row * gx + row / 2 + col + goff);
  endfunction

  task automatic issue_lookup(logic [ID_W-1:0] cur, logic [ID_W-1:0] dst, logic tie);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_current_node <= cur;
    in_target_node  <= dst;
    in_tie_bit      <= tie;
    do @(posedge clk); while (!in_ready);
    sb.note_lookup(cur, dst, tie);
    lookups++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (sb.pending_hops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_lookup();
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] dst;
    int roll;
    roll = $urandom_range(0, 99);
    cur = ID_W'(goff + $urandom_range(0, gcount - 1));
    dst = ID_W'(goff + $urandom_range(0, gcount - 1));
    if (roll >= 70 && roll < 78) begin
      if (roll >= 75) cur = ID_W'($urandom);
      dst = cur;
    end else if (roll >= 78 && roll < 86) begin
      if (goff > 0) begin
        if (roll[0]) cur = ID_W'($urandom_range(0, goff - 1));
        else dst = ID_W'($urandom_range(0, goff - 1));
      end else begin
        cur = ID_W'($urandom);
      end
    end else if (roll >= 86) begin
      cur = ID_W'($urandom);
      dst = ID_W'($urandom);
    end
    issue_lookup(cur, dst, 1'($urandom));
  endtask

  task automatic directed_lookups();
    issue_lookup('0, '0, 1'b0);
    issue_lookup('1, '1, 1'b1);
    issue_lookup('1, ID_W'(goff), 1'b1);
    issue_lookup(ID_W'(goff - 1), ID_W'(goff), 1'b0);
    issue_lookup(ID_W'(goff), ID_W'(goff - 1), 1'b1);
    issue_lookup('0, '1, 1'b1);
    issue_lookup(switch_id(0, 0), switch_id(0, 1), 1'b0);
    issue_lookup(switch_id(4, 1), switch_id(4, 0), 1'b1);
    issue_lookup(switch_id(2, 0), switch_id(2, 1), 1'b1);
    issue_lookup(switch_id(2, 0), switch_id(2, 1), 1'b0);
    issue_lookup(switch_id(2, 1), switch_id(2, 0), 1'b1);
    issue_lookup(switch_id(2, 1), switch_id(2, 0), 1'b0);
    issue_lookup(switch_id(1, 1), switch_id(3, 1), 1'b1);
    issue_lookup(switch_id(1, 1), switch_id(3, 1), 1'b0);
    issue_lookup(switch_id(1, 0), switch_id(3, 0), 1'b0);
    issue_lookup(switch_id(1, 1), switch_id(2, 1), 1'b0);
    issue_lookup(switch_id(3, 1), switch_id(1, 1), 1'b1);
    issue_lookup(switch_id(3, 1), switch_id(1, 1), 1'b0);
    issue_lookup(switch_id(3, 1), switch_id(2, 1), 1'b0);
    issue_lookup(switch_id(0, 0), switch_id(1, 2), 1'b1);
    issue_lookup(switch_id(2, 1), switch_id(0, 0), 1'b0);
    issue_lookup(switch_id(1, 2), switch_id(1, 0), 1'b1);
    issue_lookup(switch_id(3, 0), switch_id(4, 1), 1'b0);
    issue_lookup(switch_id(2, 0), switch_id(3, 2), 1'b1);
  endtask

  initial begin
    int phase;
    sb = new();
    set_geometry(RACK_SERVERS_RST, HALF_WIDTH_RST, HALF_HEIGHT_RST);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_lookups();
    await_drain();

    for (int k = 0; k < SETTINGS_N; k++) begin
      write_register(CFG_RACK_SERVERS, CFG_DATA_W'(set_rs[k]));
      write_register(CFG_HALF_WIDTH, CFG_DATA_W'(set_hw[k]));
      write_register(CFG_HALF_HEIGHT, CFG_DATA_W'(set_hh[k]));
      cfg_valid <= 1'b0;
      set_geometry(set_rs[k], set_hw[k], set_hh[k]);
      phase = k * 3 / SETTINGS_N;
      in_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 60 : 0;
      out_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 8 : 0;
      repeat (LOOKUPS_PER) random_lookup();
      await_drain();
    end

    sb.flag_leftovers();
    $display("Covered %0d lookups over %0d register settings plus reset values.",
             lookups, SETTINGS_N);
    $display("Checked %0d results: %0d arrivals, %0d rejections, %0d errors.",
             sb.checked, sb.arrivals, sb.rejections, sb.errors);
    if (sb.errors == 0) begin
      $display("** cell_topology_next_hop_router_unit: PASSED **");
    end else begin
      $display("** cell_topology_next_hop_router_unit: FAILED **");
    end
    $finish;
  end

endmodule
